// File: src/crtc_pkg.sv
// Package with shared types and constants for the CRT controller register file.
`timescale 1ns / 1ps
package crtc_pkg;
    localparam int RegisterCount = 25;
    localparam int IdxW = (RegisterCount > 1) ? $clog2(RegisterCount) : 1;

    localparam logic [1:0] CMD_WR_INDEX = 2'd0;
    localparam logic [1:0] CMD_RD_INDEX = 2'd1;
    localparam logic [1:0] CMD_WR_DATA  = 2'd2;
    localparam logic [1:0] CMD_RD_DATA  = 2'd3;

    localparam logic [7:0] CR_HDISP    = 8'h01;
    localparam logic [7:0] CR_VTOTAL   = 8'h06;
    localparam logic [7:0] CR_OVERFLOW = 8'h07;
    localparam logic [7:0] CR_PRESET   = 8'h08;
    localparam logic [7:0] CR_MAXSCAN  = 8'h09;
    localparam logic [7:0] CR_CURSTART = 8'h0a;
    localparam logic [7:0] CR_STARTHI  = 8'h0c;
    localparam logic [7:0] CR_STARTLO  = 8'h0d;
    localparam logic [7:0] CR_CURHI    = 8'h0e;
    localparam logic [7:0] CR_CURLO    = 8'h0f;
    localparam logic [7:0] CR_VRETEND  = 8'h11;
    localparam logic [7:0] CR_VDEND    = 8'h12;
    localparam logic [7:0] CR_UNDERLN  = 8'h14;
    localparam logic [7:0] CR_VBSTART  = 8'h15;
    localparam logic [7:0] CR_VBEND    = 8'h16;
    localparam logic [7:0] CR_MODE     = 8'h17;
    localparam logic [7:0] CR_LINECMP  = 8'h18;

    localparam logic [1:0] CLASS_EGA = 2'd1;
    localparam logic [1:0] CLASS_VGA = 2'd2;

    localparam logic [1:0] SHIFT_BYTE  = 2'd0;
    localparam logic [1:0] SHIFT_WORD  = 2'd1;
    localparam logic [1:0] SHIFT_DWORD = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;   // capture one transfer
        logic [1:0] cmd;
        logic [7:0] value;
    } crtc_cmd_t;
endpackage

// File: src/vga_crtc_register_file.sv
// Top level of the CRT controller register file.
// Latency: a result is valid the cycle after its input transfer.
// Throughput: one transfer per cycle while the output is not stalled; the single result register is refilled
// in the same cycle it drains.
// Reset: all registers and derived values clear, address shift is word mode,
// cursor is on and machine class is VGA.
`timescale 1ns / 1ps
module vga_crtc_register_file
    import crtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        resize_now,
    output logic        resize_later,
    output logic        retrace_irq_clear,
    output logic [15:0] start_address,
    output logic [15:0] cursor_address,
    output logic [9:0]  split_line,
    output logic [1:0]  address_shift,
    output logic [4:0]  row_scroll_skip,
    output logic [1:0]  byte_scroll_skip,
    output logic        cursor_on
);
    logic [1:0] class_reg;
    crtc_cmd_t  ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            class_reg <= CLASS_VGA;
        else if (cfg_we)
            class_reg <= cfg_data;
    end

    crtc_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .cmd, .value,
        .out_valid, .out_stall, .ctl
    );

    crtc_datapath u_dp (
        .clk, .rst_n, .ctl, .machine_class(class_reg),
        .read_data, .resize_now, .resize_later, .retrace_irq_clear,
        .start_address, .cursor_address, .split_line,
        .address_shift, .row_scroll_skip, .byte_scroll_skip, .cursor_on
    );
endmodule

// File: src/crtc_datapath.sv
// Register storage, derived display values and result register.
`timescale 1ns / 1ps
module crtc_datapath
    import crtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  crtc_cmd_t   ctl,
    input  logic [1:0]  machine_class,
    output logic [7:0]  read_data,
    output logic        resize_now,
    output logic        resize_later,
    output logic        retrace_irq_clear,
    output logic [15:0] start_address,
    output logic [15:0] cursor_address,
    output logic [9:0]  split_line,
    output logic [1:0]  address_shift,
    output logic [4:0]  row_scroll_skip,
    output logic [1:0]  byte_scroll_skip,
    output logic        cursor_on
);
    logic [7:0]  index_reg;
    logic [7:0]  regs_reg [RegisterCount];
    logic [7:0]  regs_next [RegisterCount];
    logic        wp_reg, wp_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] cur_reg, cur_next;
    logic [9:0]  split_reg, split_next;
    logic [1:0]  shift_reg, shift_next;
    logic [4:0]  rskip_reg, rskip_next;
    logic [1:0]  bskip_reg, bskip_next;
    logic        cen_reg, cen_next;
    logic [7:0]  rd_reg, rd_next;
    logic        now_reg, now_next, later_reg, later_next, irq_reg, irq_next;

    logic        known;
    logic [IdxW-1:0] idx;
    logic [7:0]  old, v, diff;
    logic        vga;

    assign known = ({24'd0, index_reg} < RegisterCount);
    assign idx   = index_reg[IdxW-1:0];
    assign old   = known ? regs_reg[idx] : 8'd0;
    assign v     = ctl.value;
    assign vga   = machine_class[1];
    assign diff  = (v > old) ? (v - old) : (old - v);

    always_comb
    begin
        logic [7:0] u14, u17;
        regs_next  = regs_reg;
        wp_next    = wp_reg;
        start_next = start_reg;
        cur_next   = cur_reg;
        split_next = split_reg;
        shift_next = shift_reg;
        rskip_next = rskip_reg;
        bskip_next = bskip_reg;
        cen_next   = cen_reg;
        rd_next    = 8'd0;
        now_next   = 1'b0;
        later_next = 1'b0;
        irq_next   = 1'b0;
        u14 = regs_reg[CR_UNDERLN[IdxW-1:0]];
        u17 = regs_reg[CR_MODE[IdxW-1:0]];
        case (ctl.cmd)
            CMD_RD_INDEX: rd_next = index_reg;
            CMD_RD_DATA:  rd_next = old;
            CMD_WR_DATA:
            begin
                if (known) begin
                    if (index_reg == CR_OVERFLOW)
                        split_next[8] = v[4];
                    if (!(index_reg <= CR_OVERFLOW && wp_reg)) begin
                        regs_next[idx] = v;
                        if (index_reg == CR_UNDERLN) u14 = v;
                        if (index_reg == CR_MODE) u17 = v;
                        case (index_reg)
                            CR_HDISP, CR_VTOTAL, CR_VBSTART, CR_VBEND:
                                now_next = (old != v);
                            CR_OVERFLOW: now_next = |((old ^ v) & 8'hd6);
                            CR_PRESET:
                            begin
                                rskip_next = v[4:0];
                                bskip_next = vga ? v[6:5] : 2'd0;
                            end
                            CR_MAXSCAN:
                            begin
                                if (vga) split_next[9] = v[6];
                                now_next = |((old ^ v) & 8'hbf);
                            end
                            CR_CURSTART: cen_next = vga ? ~v[5] : 1'b1;
                            CR_STARTHI:  start_next[15:8] = v;
                            CR_STARTLO:  start_next[7:0] = v;
                            CR_CURHI:    cur_next[15:8] = v;
                            CR_CURLO:    cur_next[7:0] = v;
                            CR_VRETEND:
                            begin
                                irq_next = (machine_class >= CLASS_EGA) && !v[4];
                                wp_next  = vga && v[7];
                            end
                            CR_VDEND:
                            begin
                                if (old != v) begin
                                    later_next = (diff < 8'd3);
                                    now_next   = !(diff < 8'd3);
                                end
                            end
                            CR_UNDERLN, CR_MODE:
                            begin
                                if (index_reg == CR_UNDERLN && !vga)
                                    shift_next = SHIFT_WORD;
                                else if (u14[5])
                                    shift_next = SHIFT_DWORD;
                                else if (u17[6])
                                    shift_next = SHIFT_BYTE;
                                else
                                    shift_next = SHIFT_WORD;
                            end
                            CR_LINECMP:  split_next[7:0] = v;
                            default: ;
                        endcase
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            index_reg <= 8'd0;
            for (int i = 0; i < RegisterCount; i++) regs_reg[i] <= 8'd0;
            wp_reg    <= 1'b0;
            start_reg <= 16'd0;
            cur_reg   <= 16'd0;
            split_reg <= 10'd0;
            shift_reg <= SHIFT_WORD;
            rskip_reg <= 5'd0;
            bskip_reg <= 2'd0;
            cen_reg   <= 1'b1;
            rd_reg    <= 8'd0;
            now_reg   <= 1'b0;
            later_reg <= 1'b0;
            irq_reg   <= 1'b0;
        end else if (ctl.load) begin
            if (ctl.cmd == CMD_WR_INDEX) index_reg <= v;
            regs_reg  <= regs_next;
            wp_reg    <= wp_next;
            start_reg <= start_next;
            cur_reg   <= cur_next;
            split_reg <= split_next;
            shift_reg <= shift_next;
            rskip_reg <= rskip_next;
            bskip_reg <= bskip_next;
            cen_reg   <= cen_next;
            rd_reg    <= rd_next;
            now_reg   <= now_next;
            later_reg <= later_next;
            irq_reg   <= irq_next;
        end
    end

    assign read_data          = rd_reg;
    assign resize_now         = now_reg;
    assign resize_later       = later_reg;
    assign retrace_irq_clear  = irq_reg;
    assign start_address      = start_reg;
    assign cursor_address     = cur_reg;
    assign split_line         = split_reg;
    assign address_shift      = shift_reg;
    assign row_scroll_skip    = rskip_reg;
    assign byte_scroll_skip   = bskip_reg;
    assign cursor_on          = cen_reg;
endmodule

// File: src/crtc_ctrl.sv
// Handshake controller: one result register with a single-entry hold.
`timescale 1ns / 1ps
module crtc_ctrl
    import crtc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] value,
    output logic       out_valid,
    input  logic       out_stall,
    output crtc_cmd_t  ctl
);
    typedef enum logic {ST_EMPTY, ST_FULL} state_t;
    state_t state_reg, state_next;
    logic   take;

    // A new transfer is taken when the result slot is empty or being drained.
    assign in_stall  = (state_reg == ST_FULL) && out_stall;
    assign take      = in_valid && !in_stall;
    assign ctl.load  = take;
    assign ctl.cmd   = cmd;
    assign ctl.value = value;
    assign out_valid = (state_reg == ST_FULL);

    always_comb
    begin
        case (state_reg)
            ST_EMPTY: state_next = take ? ST_FULL : ST_EMPTY;
            ST_FULL:  state_next = (take || out_stall) ? ST_FULL : ST_EMPTY;
            default:  state_next = ST_EMPTY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_EMPTY;
        else
            state_reg <= state_next;
    end
endmodule
